[rtl/core/ik_pkg.sv]
// ----------------------------------------------------------------------------
// ik_pkg: shared types, constants and helpers for the two-link IK core
// Widths of the pipeline, the CORDIC angle table and angle rounding.
// ----------------------------------------------------------------------------
package ik_pkg;

  localparam int FRAC      = 16;
  localparam int SH        = 30 - FRAC;
  localparam int ANG_W     = 19;
  localparam int POS_W     = 20;
  localparam int LEN_W     = 19;
  localparam int MAG_W     = 41;
  localparam int REM_W     = 42;
  localparam int DEN_W     = 39;
  localparam int DIV_STEPS = 30;
  localparam int SQ_W      = 62;
  localparam int SQ_STEPS  = 31;
  localparam int CW        = 56;
  localparam int ZW        = 34;
  localparam int STEPS     = 28;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam longint PI_Q30   = 64'sd3373259426;
  localparam longint HALF_LSB = 64'sd1 <<< (SH - 1);
  localparam longint PI_Q     = (PI_Q30 + HALF_LSB) >>> SH;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_REACH = 2'd1,
    ST_RANGE = 2'd2
  } ik_status_e;

  typedef enum logic [2:0] {
    REG_L1    = 3'd0,
    REG_L2    = 3'd1,
    REG_SMIN  = 3'd2,
    REG_SMAX  = 3'd3,
    REG_EMIN  = 3'd4,
    REG_EMAX  = 3'd5,
    REG_FIXED = 3'd6
  } ik_reg_e;

  typedef struct packed {
    logic                    unreach;
    logic                    num_neg;
    logic                    sat;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [31:0]      c2;
    logic [30:0]             sq;
  } ik_meta_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } ik_rot_t;

  function automatic logic signed [ZW-1:0] atan_q30(int unsigned i);
    logic signed [ZW-1:0] a;
    case (i)
      0:  a = 34'sh03243F6A8;
      1:  a = 34'sh01DAC6705;
      2:  a = 34'sh00FADBAFC;
      3:  a = 34'sh007F56EA6;
      4:  a = 34'sh003FEAB76;
      5:  a = 34'sh001FFD55B;
      6:  a = 34'sh000FFFAAA;
      7:  a = 34'sh0007FFF55;
      8:  a = 34'sh0003FFFEA;
      9:  a = 34'sh0001FFFFD;
      10: a = 34'sh0000FFFFF;
      11: a = 34'sh00007FFFF;
      12: a = 34'sh00003FFFF;
      13: a = 34'sh00001FFFF;
      14: a = 34'sh00000FFFF;
      15: a = 34'sh000007FFF;
      16: a = 34'sh000003FFF;
      17: a = 34'sh000001FFF;
      18: a = 34'sh000000FFF;
      19: a = 34'sh0000007FF;
      20: a = 34'sh0000003FF;
      21: a = 34'sh0000001FF;
      22: a = 34'sh0000000FF;
      23: a = 34'sh00000007F;
      24: a = 34'sh00000003F;
      25: a = 34'sh00000001F;
      26: a = 34'sh00000000F;
      27: a = 34'sh000000007;
      default: a = '0;
    endcase
    return a;
  endfunction

  // One micro-rotation towards y = 0, shifts are floor shifts.
  function automatic ik_rot_t cordic_iter(ik_rot_t r, int unsigned i);
    ik_rot_t o;
    logic signed [CW-1:0] xv, yv, xs, ys;
    xv = r.x;
    yv = r.y;
    xs = xv >>> i;
    ys = yv >>> i;
    if (!yv[CW-1]) begin
      o.x = xv + ys;
      o.y = yv - xs;
      o.z = r.z + atan_q30(i);
    end else begin
      o.x = xv - ys;
      o.y = yv + xs;
      o.z = r.z - atan_q30(i);
    end
    return o;
  endfunction

  // Round a Q30 angle to the output format and saturate to +/- pi.
  function automatic logic signed [ANG_W-1:0] to_angle(logic signed [ZW-1:0] z);
    logic signed [ZW:0] t;
    logic signed [ZW:0] a;
    logic signed [ZW:0] lim;
    t   = $signed({z[ZW-1], z}) + $signed((ZW+1)'(HALF_LSB));
    a   = t >>> SH;
    lim = $signed((ZW+1)'(PI_Q));
    if (a > lim) a = lim;
    if (a < -lim) a = -lim;
    return a[ANG_W-1:0];
  endfunction

endpackage

[rtl/core/two_link_inverse_kinematics_core.sv]
// Throughput: one target per cycle; busy_o stays low, the pipeline never stalls.
// The datapath includes the 30-stage divider, the 31-stage root and the 29-stage CORDIC.
// Reset clears all valid bits and loads the configuration register reset values.
// Results are strobed by done_o for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics_core: planar two-link arm inverse kinematics
// Solves shoulder and elbow angles from a target point, with reach and
// joint range checks, through a fully pipelined datapath.
// ----------------------------------------------------------------------------
module two_link_inverse_kinematics_core import ik_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [4:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic signed [POS_W-1:0] target_x_i,
  input  logic signed [POS_W-1:0] target_y_i,
  output logic                    done_o,
  output logic signed [ANG_W-1:0] shoulder_angle_o,
  output logic signed [ANG_W-1:0] elbow_angle_o,
  output logic [1:0]              status_o
);

  // Configuration registers.
  logic [LEN_W-1:0]        l1_q, l2_q;
  logic signed [ANG_W-1:0] smin_q, smax_q, emin_q, emax_q;
  logic                    fix_q;
  ik_reg_e                 reg_sel;

  assign pready  = 1'b1;
  assign busy_o  = 1'b0;
  assign reg_sel = ik_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q   <= '0;
      l2_q   <= '0;
      smin_q <= -$signed(ANG_W'(PI_Q));
      smax_q <= $signed(ANG_W'(PI_Q));
      emin_q <= -$signed(ANG_W'(PI_Q));
      emax_q <= $signed(ANG_W'(PI_Q));
      fix_q  <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_L1:    l1_q   <= pwdata[LEN_W-1:0];
        REG_L2:    l2_q   <= pwdata[LEN_W-1:0];
        REG_SMIN:  smin_q <= pwdata[ANG_W-1:0];
        REG_SMAX:  smax_q <= pwdata[ANG_W-1:0];
        REG_EMIN:  emin_q <= pwdata[ANG_W-1:0];
        REG_EMAX:  emax_q <= pwdata[ANG_W-1:0];
        REG_FIXED: fix_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_L1:    prdata = 32'(l1_q);
      REG_L2:    prdata = 32'(l2_q);
      REG_SMIN:  prdata = 32'(unsigned'(smin_q));
      REG_SMAX:  prdata = 32'(unsigned'(smax_q));
      REG_EMIN:  prdata = 32'(unsigned'(emin_q));
      REG_EMAX:  prdata = 32'(unsigned'(emax_q));
      REG_FIXED: prdata = 32'(fix_q);
      default:   prdata = '0;
    endcase
  end

  // Terms that depend on the link lengths alone, registered from the link
  // length registers.
  logic [37:0]      ll1_q, ll2_q, lp_q, dd_q;
  logic [38:0]      lsum_q;
  logic [DEN_W-1:0] den_q;
  logic [39:0]      ss_q;
  logic             lzero_q;
  logic [LEN_W-1:0] ldiff;
  logic [LEN_W:0]   lsumlen;

  assign ldiff   = (l1_q >= l2_q) ? l1_q - l2_q : l2_q - l1_q;
  assign lsumlen = {1'b0, l1_q} + {1'b0, l2_q};

  always_ff @(posedge clk_i) begin
    ll1_q   <= l1_q * l1_q;
    ll2_q   <= l2_q * l2_q;
    lp_q    <= l1_q * l2_q;
    dd_q    <= ldiff * ldiff;
    ss_q    <= lsumlen * lsumlen;
    lsum_q  <= {1'b0, ll1_q} + {1'b0, ll2_q};
    den_q   <= {lp_q, 1'b0};
    lzero_q <= (l1_q == '0) || (l2_q == '0);
  end

  // Stage 1: accepted target.
  logic                    v1_q;
  logic signed [POS_W-1:0] x1_q, y1_q;
  // Stage 2: squares.
  logic                    v2_q;
  logic [38:0]             xx2_q, yy2_q;
  logic signed [POS_W-1:0] x2_q, y2_q;
  logic signed [39:0]      xsq, ysq;
  // Stage 3: squared radius.
  logic                    v3_q;
  logic [39:0]             r2_3_q;
  logic signed [POS_W-1:0] x3_q, y3_q;
  // Stage 4: cosine numerator and reach test.
  logic                    v4_q;
  logic signed [41:0]      num4_q;
  logic                    unr4_q;
  logic signed [POS_W-1:0] x4_q, y4_q;
  // Stage 5: magnitude and clamp test.
  logic                    v5_q;
  logic [MAG_W-1:0]        mag5_q;
  ik_meta_t                m5_q;
  logic [MAG_W-1:0]        mag4;

  assign xsq  = x1_q * x1_q;
  assign ysq  = y1_q * y1_q;
  assign mag4 = num4_q[41] ? MAG_W'(-num4_q) : MAG_W'(num4_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q   <= target_x_i;
    y1_q   <= target_y_i;
    xx2_q  <= xsq[38:0];
    yy2_q  <= ysq[38:0];
    x2_q   <= x1_q;
    y2_q   <= y1_q;
    r2_3_q <= {1'b0, xx2_q} + {1'b0, yy2_q};
    x3_q   <= x2_q;
    y3_q   <= y2_q;
    num4_q <= $signed({2'b0, r2_3_q}) - $signed({3'b0, lsum_q});
    unr4_q <= lzero_q || (r2_3_q < {2'b0, dd_q}) || (r2_3_q > ss_q);
    x4_q   <= x3_q;
    y4_q   <= y3_q;
    mag5_q <= mag4;
    m5_q.unreach <= unr4_q;
    m5_q.num_neg <= num4_q[41];
    m5_q.sat     <= mag4 >= MAG_W'(den_q);
    m5_q.x       <= x4_q;
    m5_q.y       <= y4_q;
    m5_q.c2      <= '0;
    m5_q.sq      <= '0;
  end

  // Divider.
  logic                 vd;
  logic [DIV_STEPS-1:0] qd;
  ik_meta_t             md;

  ik_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v5_q),
    .mag_i   (mag5_q),
    .den_i   (den_q),
    .meta_i  (m5_q),
    .valid_o (vd),
    .q_o     (qd),
    .meta_o  (md)
  );

  // Stage 6: signed, clamped cosine. Stage 7: its square. Stage 8: 1 - C2^2.
  logic               v6_q, v7_q, v8_q;
  ik_meta_t           m6_q, m7_q, m8_q;
  ik_meta_t           m6_d;
  logic [30:0]        cmag;
  logic signed [31:0] c2_6;
  logic signed [63:0] c2sq;
  logic [60:0]        c2sq7_q;
  logic [60:0]        rad8_q;

  assign cmag = md.sat ? 31'h4000_0000 : {1'b0, qd};
  assign c2_6 = md.num_neg ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
  assign c2sq = m6_q.c2 * m6_q.c2;

  always_comb begin
    m6_d    = md;
    m6_d.c2 = c2_6;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      v6_q <= vd;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m6_q    <= m6_d;
    c2sq7_q <= c2sq[60:0];
    m7_q    <= m6_q;
    rad8_q  <= (61'(1) << 60) - c2sq7_q;
    m8_q    <= m7_q;
  end

  // Square root for |S2|.
  logic        vs;
  logic [30:0] root;
  ik_meta_t    ms;

  ik_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v8_q),
    .rad_i   (rad8_q),
    .meta_i  (m8_q),
    .valid_o (vs),
    .root_o  (root),
    .meta_o  (ms)
  );

  // P1: L2*C2 and L2*|S2|. P2: k1, k2. P3: products with x, y. P4: atan2 args.
  logic               vp1_q, vp2_q, vp3_q, vp4_q;
  ik_meta_t           mp1_q, mp2_q, mp3_q, mp4_q;
  ik_meta_t           mp1_d;
  logic signed [51:0] m1_q;
  logic [49:0]        m2_q;
  logic signed [52:0] k1sum;
  logic signed [50:0] k2neg;
  logic signed [32:0] k1_q;
  logic signed [30:0] k2_q;
  logic signed [52:0] k1x_q, k1y_q;
  logic signed [50:0] k2x_q, k2y_q;
  logic signed [53:0] bx_q, by_q;

  assign k1sum = $signed({3'b0, l1_q, 30'b0}) + {m1_q[51], m1_q};
  assign k2neg = -$signed({1'b0, m2_q});

  always_comb begin
    mp1_d    = ms;
    mp1_d.sq = root;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp1_q <= 1'b0;
      vp2_q <= 1'b0;
      vp3_q <= 1'b0;
      vp4_q <= 1'b0;
    end else begin
      vp1_q <= vs;
      vp2_q <= vp1_q;
      vp3_q <= vp2_q;
      vp4_q <= vp3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mp1_q    <= mp1_d;
    m1_q     <= $signed({1'b0, l2_q}) * ms.c2;
    m2_q     <= l2_q * root;
    mp2_q    <= mp1_q;
    k1_q     <= k1sum[52:20];
    k2_q     <= k2neg[50:20];
    mp3_q    <= mp2_q;
    k1x_q    <= k1_q * mp2_q.x;
    k1y_q    <= k1_q * mp2_q.y;
    k2x_q    <= k2_q * mp2_q.x;
    k2y_q    <= k2_q * mp2_q.y;
    mp4_q    <= mp3_q;
    bx_q     <= {k1x_q[52], k1x_q} + 54'(k2y_q);
    by_q     <= {k1y_q[52], k1y_q} - 54'(k2x_q);
  end

  // Lane 0: shoulder atan2(by, bx). Lane 1: elbow atan2(|S2|, C2).
  logic signed [CW-1:0] cx [2];
  logic signed [CW-1:0] cy [2];
  logic signed [ZW-1:0] cz [2];
  logic                 vc;
  ik_meta_t             mc;

  assign cx[0] = CW'(bx_q);
  assign cy[0] = CW'(by_q);
  assign cx[1] = CW'(mp4_q.c2);
  assign cy[1] = CW'({1'b0, mp4_q.sq});

  ik_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vp4_q),
    .x_i     (cx),
    .y_i     (cy),
    .meta_i  (mp4_q),
    .valid_o (vc),
    .z_o     (cz),
    .meta_o  (mc)
  );

  // F1: rounding to output format. F2: range check and result registers.
  logic                    vf_q;
  logic                    unrf_q;
  logic signed [ANG_W-1:0] sa_q, ea_q;
  logic                    in_range;

  assign in_range = fix_q && (sa_q >= smin_q) && (sa_q <= smax_q)
                    && (ea_q >= emin_q) && (ea_q <= emax_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q   <= 1'b0;
      done_o <= 1'b0;
    end else begin
      vf_q   <= vc;
      done_o <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    unrf_q <= mc.unreach;
    sa_q   <= to_angle(cz[0]);
    ea_q   <= to_angle(-cz[1]);
    if (unrf_q) begin
      shoulder_angle_o <= '0;
      elbow_angle_o    <= '0;
      status_o         <= ST_REACH;
    end else begin
      shoulder_angle_o <= sa_q;
      elbow_angle_o    <= ea_q;
      status_o         <= in_range ? ST_OK : ST_RANGE;
    end
  end

endmodule

[rtl/core/ik_div.sv]
// ----------------------------------------------------------------------------
// ik_div: pipelined restoring divider
// Produces one quotient bit per stage for the Q30 cosine of the elbow.
// ----------------------------------------------------------------------------
module ik_div import ik_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [MAG_W-1:0]     mag_i,
  input  logic [DEN_W-1:0]     den_i,
  input  ik_meta_t             meta_i,
  output logic                 valid_o,
  output logic [DIV_STEPS-1:0] q_o,
  output ik_meta_t             meta_o
);

  logic                 v_q    [DIV_STEPS+1];
  logic [REM_W-1:0]     rem_q  [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] q_q    [DIV_STEPS+1];
  ik_meta_t             meta_q [DIV_STEPS+1];

  assign v_q[0]    = valid_i;
  assign rem_q[0]  = {1'b0, mag_i};
  assign q_q[0]    = '0;
  assign meta_q[0] = meta_i;

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_stage
    logic [REM_W-1:0] rem2;
    logic             take;
    assign rem2 = {rem_q[k-1][REM_W-2:0], 1'b0};
    assign take = rem2 >= REM_W'(den_i);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= take ? rem2 - REM_W'(den_i) : rem2;
      q_q[k]    <= {q_q[k-1][DIV_STEPS-2:0], take};
      meta_q[k] <= meta_q[k-1];
    end
  end

  assign valid_o = v_q[DIV_STEPS];
  assign q_o     = q_q[DIV_STEPS];
  assign meta_o  = meta_q[DIV_STEPS];

endmodule

[rtl/core/ik_sqrt.sv]
// ----------------------------------------------------------------------------
// ik_sqrt: pipelined integer square root
// One result bit per stage, remainder form, floor of the root.
// ----------------------------------------------------------------------------
module ik_sqrt import ik_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [60:0] rad_i,
  input  ik_meta_t    meta_i,
  output logic        valid_o,
  output logic [30:0] root_o,
  output ik_meta_t    meta_o
);

  logic            v_q    [SQ_STEPS+1];
  logic [SQ_W-1:0] val_q  [SQ_STEPS+1];
  logic [SQ_W-1:0] res_q  [SQ_STEPS+1];
  ik_meta_t        meta_q [SQ_STEPS+1];

  assign v_q[0]    = valid_i;
  assign val_q[0]  = SQ_W'(rad_i);
  assign res_q[0]  = '0;
  assign meta_q[0] = meta_i;

  for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_stage
    localparam logic [SQ_W-1:0] Bit = SQ_W'(1) << (60 - 2 * (k - 1));
    logic [SQ_W-1:0] trial;
    logic            take;
    assign trial = res_q[k-1] + Bit;
    assign take  = val_q[k-1] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      val_q[k]  <= take ? val_q[k-1] - trial : val_q[k-1];
      res_q[k]  <= take ? (res_q[k-1] >> 1) + Bit : res_q[k-1] >> 1;
      meta_q[k] <= meta_q[k-1];
    end
  end

  assign valid_o = v_q[SQ_STEPS];
  assign root_o  = res_q[SQ_STEPS][30:0];
  assign meta_o  = meta_q[SQ_STEPS];

endmodule

[rtl/core/ik_cordic.sv]
// ----------------------------------------------------------------------------
// ik_cordic: two-lane pipelined CORDIC atan2
// Lane 0 solves the shoulder, lane 1 the elbow, one micro-rotation a stage.
// ----------------------------------------------------------------------------
module ik_cordic import ik_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] x_i [2],
  input  logic signed [CW-1:0] y_i [2],
  input  ik_meta_t             meta_i,
  output logic                 valid_o,
  output logic signed [ZW-1:0] z_o [2],
  output ik_meta_t             meta_o
);

  logic     v_q    [STEPS+1];
  ik_rot_t  rot_q  [STEPS+1][2];
  logic     zero_q [STEPS+1][2];
  ik_meta_t meta_q [STEPS+1];

  // Quadrant pre-rotation by a quarter turn for targets left of the y axis.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    meta_q[0] <= meta_i;
    for (int l = 0; l < 2; l++) begin
      zero_q[0][l] <= (x_i[l] == '0) && (y_i[l] == '0);
      if (x_i[l][CW-1]) begin
        if (!y_i[l][CW-1]) begin
          rot_q[0][l].x <= y_i[l];
          rot_q[0][l].y <= -x_i[l];
          rot_q[0][l].z <= HALF_PI_Q30;
        end else begin
          rot_q[0][l].x <= -y_i[l];
          rot_q[0][l].y <= x_i[l];
          rot_q[0][l].z <= -HALF_PI_Q30;
        end
      end else begin
        rot_q[0][l].x <= x_i[l];
        rot_q[0][l].y <= y_i[l];
        rot_q[0][l].z <= '0;
      end
    end
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      meta_q[k] <= meta_q[k-1];
      for (int l = 0; l < 2; l++) begin
        rot_q[k][l]  <= cordic_iter(rot_q[k-1][l], k - 1);
        zero_q[k][l] <= zero_q[k-1][l];
      end
    end
  end

  assign valid_o = v_q[STEPS];
  assign meta_o  = meta_q[STEPS];
  assign z_o[0]  = zero_q[STEPS][0] ? '0 : rot_q[STEPS][0].z;
  assign z_o[1]  = zero_q[STEPS][1] ? '0 : rot_q[STEPS][1].z;

endmodule
